FILE: src/volume_stencil_filter_3x3x3_macros.svh
// assertion macros for the volume stencil filter
`ifndef VOLUME_STENCIL_FILTER_3X3X3_MACROS_SVH
`define VOLUME_STENCIL_FILTER_3X3X3_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define VSF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vsf assertion failed");
// next-cycle implication
`define VSF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vsf assertion failed");
`else
`define VSF_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define VSF_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/vsf_pkg.sv
package vsf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VOL_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FACE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_EDGE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER  = 3'd7;

  typedef enum logic [1:0] {
    MODE_LAPLACE = 2'd0,
    MODE_GAUSS   = 2'd1,
    MODE_SOBEL_X = 2'd2,
    MODE_OFF     = 2'd3
  } vsf_mode_e;

  // one stream item handed from the front to the back
  typedef struct packed {
    logic [7:0] voxel;
    logic       emit;   // this item completes a neighbourhood
    logic       last;   // that result is the final voxel of the volume
    logic [5:0] nb_ok;  // x-, x+, y-, y+, z-, z+ neighbours inside the volume
  } vsf_item_t;

  typedef struct packed {
    logic idle;
    logic draining;
  } vsf_front_status_t;

endpackage

FILE: src/vsf_delay.sv
module vsf_delay import vsf_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [$clog2(DEPTH+1)-1:0] len_i,
  input  logic [7:0]                 din_i,
  output logic [7:0]                 dout_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] ptr_q, ptr_d, addr;
  logic [7:0]    dout_q;

  // a pointer left beyond a shorter length restarts the ring at zero
  assign addr = (LW'(ptr_q) >= len_i) ? '0 : ptr_q;

  always_comb begin
    if (LW'(addr) + LW'(1) >= len_i) begin
      ptr_d = '0;
    end else begin
      ptr_d = addr + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (en_i) begin
      ptr_q <= ptr_d;
    end
  end

  // read before write gives a delay of len_i transactions
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (len_i == '0) begin
        dout_q <= din_i;
      end else begin
        dout_q <= mem[addr];
      end
      mem[addr] <= din_i;
    end
  end

  assign dout_o = dout_q;

endmodule

FILE: src/vsf_fifo.sv
module vsf_fifo import vsf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  vsf_item_t push_data_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output vsf_item_t pop_data_o
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  vsf_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q, cnt_d;

  assign ready_o    = cnt_q != (PW+1)'(DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/vsf_front.sv
module vsf_front import vsf_pkg::*; #(
  parameter int WW = 8,
  parameter int HW = 8,
  parameter int DW = 11,
  parameter int PW = 15,
  parameter int FW = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WW-1:0]     w_i,
  input  logic [HW-1:0]     h_i,
  input  logic [DW-1:0]     d_i,
  input  logic [PW-1:0]     plane_i,
  input  logic              accept_i,
  input  logic [7:0]        voxel_i,
  input  logic              is_pad_i,
  output logic              push_o,
  output vsf_item_t         push_data_o,
  output vsf_front_status_t status_o
);

  logic [WW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [DW-1:0] in_plane_q, in_plane_d, out_plane_q, out_plane_d;
  logic [FW-1:0] fill_q, fill_d, fill_inc, lag1;
  logic          at_start, draining, stream, emit, last;

  assign lag1     = FW'(plane_i) + FW'(w_i) + FW'(2);
  assign at_start = (in_col_q == '0) && (in_row_q == '0) && (in_plane_q == '0);
  assign draining = at_start && (fill_q != '0);
  assign stream   = draining || !is_pad_i;
  assign fill_inc = (fill_q >= lag1) ? lag1 : fill_q + FW'(1);
  assign emit     = fill_inc == lag1;
  assign last     = (out_col_q + WW'(1) >= w_i) && (out_row_q + HW'(1) >= h_i) &&
                    (out_plane_q + DW'(1) >= d_i);

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_plane_d = in_plane_q;
    if (in_col_q + WW'(1) < w_i) begin
      in_col_d = in_col_q + WW'(1);
    end else begin
      in_col_d = '0;
      if (in_row_q + HW'(1) < h_i) begin
        in_row_d = in_row_q + HW'(1);
      end else begin
        in_row_d = '0;
        if (in_plane_q + DW'(1) < d_i) begin
          in_plane_d = in_plane_q + DW'(1);
        end else begin
          in_plane_d = '0;
        end
      end
    end
  end

  always_comb begin
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_plane_d = out_plane_q;
    if (out_col_q + WW'(1) < w_i) begin
      out_col_d = out_col_q + WW'(1);
    end else begin
      out_col_d = '0;
      if (out_row_q + HW'(1) < h_i) begin
        out_row_d = out_row_q + HW'(1);
      end else begin
        out_row_d = '0;
        if (out_plane_q + DW'(1) < d_i) begin
          out_plane_d = out_plane_q + DW'(1);
        end else begin
          out_plane_d = '0;
        end
      end
    end
  end

  always_comb begin
    fill_d = fill_inc;
    if (emit) begin
      fill_d = last ? '0 : lag1 - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_plane_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_plane_q <= '0;
      fill_q      <= '0;
    end else if (accept_i && stream) begin
      fill_q <= fill_d;
      // a voxel sent during draining is dropped and does not move the input position
      if (!draining) begin
        in_col_q   <= in_col_d;
        in_row_q   <= in_row_d;
        in_plane_q <= in_plane_d;
      end
      if (emit) begin
        out_col_q   <= out_col_d;
        out_row_q   <= out_row_d;
        out_plane_q <= out_plane_d;
      end
    end
  end

  assign push_o                = accept_i && stream;
  assign push_data_o.voxel     = draining ? 8'd0 : voxel_i;
  assign push_data_o.emit      = emit;
  assign push_data_o.last      = last;
  assign push_data_o.nb_ok[0]  = out_col_q != '0;
  assign push_data_o.nb_ok[1]  = out_col_q + WW'(1) < w_i;
  assign push_data_o.nb_ok[2]  = out_row_q != '0;
  assign push_data_o.nb_ok[3]  = out_row_q + HW'(1) < h_i;
  assign push_data_o.nb_ok[4]  = out_plane_q != '0;
  assign push_data_o.nb_ok[5]  = out_plane_q + DW'(1) < d_i;
  assign status_o.idle         = at_start && (fill_q == '0);
  assign status_o.draining     = draining;

endmodule

FILE: src/vsf_back.sv
module vsf_back import vsf_pkg::*; #(
  parameter int MAX_WIDTH      = 128,
  parameter int MAX_HEIGHT     = 128,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]             w_i,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]  plane_i,
  input  vsf_mode_e                                  mode_i,
  input  logic [3:0][15:0]                           coef_i,
  input  logic                                       q_valid_i,
  input  vsf_item_t                                  q_data_i,
  output logic                                       q_pop_o,
  output logic                                       out_valid_o,
  output logic [7:0]                                 out_data_o,
  output logic                                       out_last_o,
  input  logic                                       out_ready_i
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int PW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);

  logic       adv, pop;
  logic [7:0] head [3][3];
  logic [7:0] t1_q [3][3];
  logic [7:0] t2_q [3][3];
  logic [7:0] x0_q;
  logic [WW-1:0] wm1;
  logic [PW-1:0] pm1;

  assign adv     = !out_valid_o || out_ready_i;
  assign pop     = q_valid_i && adv;
  assign q_pop_o = pop;
  assign wm1     = w_i - WW'(1);
  assign pm1     = plane_i - PW'(1);

  // row and plane delay lines; head[a][b] is the stream delayed by a planes and b rows
  always_ff @(posedge clk_i) begin
    if (pop) begin
      x0_q <= q_data_i.voxel;
    end
  end
  assign head[0][0] = x0_q;

  vsf_delay #(.DEPTH(MAX_WIDTH)) u_row01 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(w_i), .din_i(q_data_i.voxel), .dout_o(head[0][1]));
  vsf_delay #(.DEPTH(MAX_WIDTH)) u_row02 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(wm1), .din_i(head[0][1]), .dout_o(head[0][2]));
  vsf_delay #(.DEPTH(MAX_WIDTH*MAX_HEIGHT)) u_plane1 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(plane_i), .din_i(q_data_i.voxel),
    .dout_o(head[1][0]));
  vsf_delay #(.DEPTH(MAX_WIDTH)) u_row11 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(wm1), .din_i(head[1][0]), .dout_o(head[1][1]));
  vsf_delay #(.DEPTH(MAX_WIDTH)) u_row12 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(wm1), .din_i(head[1][1]), .dout_o(head[1][2]));
  vsf_delay #(.DEPTH(MAX_WIDTH*MAX_HEIGHT)) u_plane2 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(pm1), .din_i(head[1][0]), .dout_o(head[2][0]));
  vsf_delay #(.DEPTH(MAX_WIDTH)) u_row21 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(wm1), .din_i(head[2][0]), .dout_o(head[2][1]));
  vsf_delay #(.DEPTH(MAX_WIDTH)) u_row22 (
    .clk_i, .rst_ni, .en_i(pop), .len_i(wm1), .din_i(head[2][1]), .dout_o(head[2][2]));

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          t1_q[a][b] <= head[a][b];
          t2_q[a][b] <= t1_q[a][b];
        end
      end
    end
  end

  // stage 1: window is in the taps
  logic       s1_valid_q, s1_last_q;
  logic [5:0] s1_ok_q;

  // stage 2: class sums
  logic               s2_valid_q, s2_last_q;
  logic [7:0]         c_d, c_q;
  logic [10:0]        face_d, face_q, corner_d, corner_q;
  logic [11:0]        edge_d, edge_q;
  logic signed [12:0] sob_d, sob_q;

  always_comb begin
    logic [7:0] v;
    logic       okx, oky, okz;
    logic [1:0] cls;
    c_d      = '0;
    face_d   = '0;
    edge_d   = '0;
    corner_d = '0;
    sob_d    = '0;
    for (int iz = 0; iz < 3; iz++) begin
      for (int iy = 0; iy < 3; iy++) begin
        for (int ix = 0; ix < 3; ix++) begin
          okx = (ix == 0) ? s1_ok_q[0] : (ix == 2) ? s1_ok_q[1] : 1'b1;
          oky = (iy == 0) ? s1_ok_q[2] : (iy == 2) ? s1_ok_q[3] : 1'b1;
          okz = (iz == 0) ? s1_ok_q[4] : (iz == 2) ? s1_ok_q[5] : 1'b1;
          if (ix == 2) begin
            v = head[2-iz][2-iy];
          end else if (ix == 1) begin
            v = t1_q[2-iz][2-iy];
          end else begin
            v = t2_q[2-iz][2-iy];
          end
          if (!(okx && oky && okz)) begin
            v = 8'd0;
          end
          cls = 2'(ix != 1) + 2'(iy != 1) + 2'(iz != 1);
          case (cls)
            2'd0:    c_d      = v;
            2'd1:    face_d   = face_d + 11'(v);
            2'd2:    edge_d   = edge_d + 12'(v);
            default: corner_d = corner_d + 11'(v);
          endcase
          if (iz == 1 && ix != 1) begin
            if (ix == 2) begin
              sob_d = sob_d + ((iy == 1) ? 13'sd2 : 13'sd1) * $signed({5'd0, v});
            end else begin
              sob_d = sob_d - ((iy == 1) ? 13'sd2 : 13'sd1) * $signed({5'd0, v});
            end
          end
        end
      end
    end
  end

  // stage 3: gaussian products and linear response magnitude
  logic               s3_valid_q, s3_last_q;
  logic [27:0]        prod_q [4];
  logic [7:0]         lin_q;
  logic signed [12:0] lin_s;
  logic [12:0]        lin_abs;

  always_comb begin
    if (mode_i == MODE_SOBEL_X) begin
      lin_s = sob_q;
    end else begin
      lin_s = $signed({2'd0, face_q}) - 13'sd6 * $signed({5'd0, c_q});
    end
    lin_abs = lin_s[12] ? 13'(-lin_s) : 13'(lin_s);
  end

  // stage 4: output register
  logic [29:0] gsum;
  logic [29:0] gsh;
  logic [7:0]  res;

  always_comb begin
    gsum = 30'(prod_q[0]) + 30'(prod_q[1]) + 30'(prod_q[2]) + 30'(prod_q[3]);
    gsh  = gsum >> COEF_FRAC_BITS;
    case (mode_i) inside
      MODE_GAUSS:                 res = (gsh > 30'd255) ? 8'd255 : gsh[7:0];
      MODE_LAPLACE, MODE_SOBEL_X: res = lin_q;
      default:                    res = 8'd0;
    endcase
  end

  logic       out_valid_q, out_last_q;
  logic [7:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop && q_data_i.emit;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q  <= q_data_i.last;
      s1_ok_q    <= q_data_i.nb_ok;
      s2_last_q  <= s1_last_q;
      c_q        <= c_d;
      face_q     <= face_d;
      edge_q     <= edge_d;
      corner_q   <= corner_d;
      sob_q      <= sob_d;
      s3_last_q  <= s2_last_q;
      prod_q[0]  <= coef_i[0] * 12'(c_q);
      prod_q[1]  <= coef_i[1] * 12'(face_q);
      prod_q[2]  <= coef_i[2] * edge_q;
      prod_q[3]  <= coef_i[3] * 12'(corner_q);
      lin_q      <= (lin_abs > 13'd255) ? 8'd255 : lin_abs[7:0];
      out_last_q <= s3_last_q;
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: src/volume_stencil_filter_3x3x3.sv
// a result leaves after the stream transaction that completes its 3x3x3 neighbourhood,
//   passing the queue read, window taps, class sums, products and output register
// throughput: one voxel per cycle unless the output stalls, set by one pop of the item queue per cycle
// results lag the input by plane + row + 1 stream items; pad items flush the tail
// reset: counters, queue and pipeline valids clear, registers return to defaults;
//   the plane and row delay memories are not cleared, out-of-volume taps are masked
`include "volume_stencil_filter_3x3x3_macros.svh"

module volume_stencil_filter_3x3x3 import vsf_pkg::*; #(
  parameter int MAX_WIDTH      = 128,
  parameter int MAX_HEIGHT     = 128,
  parameter int MAX_DEPTH      = 1024,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // voxel
  input  logic                  s_axis_tuser,   // is_pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // filtered_voxel
  output logic                  m_axis_tlast    // last_voxel
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int DW = $clog2(MAX_DEPTH+1);
  localparam int PW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int FW = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+3);

  logic [7:0]       vol_width_q, vol_height_q;
  logic [10:0]      vol_depth_q;
  vsf_mode_e        mode_q;
  logic [3:0][15:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_width_q  <= 8'd128;
      vol_height_q <= 8'd128;
      vol_depth_q  <= 11'd128;
      mode_q       <= MODE_LAPLACE;
      coef_q[0]    <= 16'd1634;
      coef_q[1]    <= 16'd991;
      coef_q[2]    <= 16'd601;
      coef_q[3]    <= 16'd365;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VOL_WIDTH:   vol_width_q  <= cfg_data_i[7:0];
        REG_VOL_HEIGHT:  vol_height_q <= cfg_data_i[7:0];
        REG_VOL_DEPTH:   vol_depth_q  <= cfg_data_i[10:0];
        REG_FILTER_MODE: mode_q       <= vsf_mode_e'(cfg_data_i[1:0]);
        REG_COEF_CENTER: coef_q[0]    <= cfg_data_i;
        REG_COEF_FACE:   coef_q[1]    <= cfg_data_i;
        REG_COEF_EDGE:   coef_q[2]    <= cfg_data_i;
        REG_COEF_CORNER: coef_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sizes of zero act as one, sizes above the maximum act as the maximum
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [DW-1:0] d;
  logic [PW-1:0] plane;

  assign w = (vol_width_q == '0) ? WW'(1) :
             (32'(vol_width_q) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(vol_width_q);
  assign h = (vol_height_q == '0) ? HW'(1) :
             (32'(vol_height_q) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(vol_height_q);
  assign d = (vol_depth_q == '0) ? DW'(1) :
             (32'(vol_depth_q) > 32'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(vol_depth_q);
  assign plane = PW'(w) * PW'(h);

  logic              in_accept, q_push, q_ready, q_pop, q_valid;
  vsf_item_t         q_in, q_out;
  vsf_front_status_t front_st;

  assign s_axis_tready = q_ready;
  assign in_accept     = s_axis_tvalid && q_ready;

  vsf_front #(.WW(WW), .HW(HW), .DW(DW), .PW(PW), .FW(FW)) u_front (
    .clk_i,
    .rst_ni,
    .w_i         (w),
    .h_i         (h),
    .d_i         (d),
    .plane_i     (plane),
    .accept_i    (in_accept),
    .voxel_i     (s_axis_tdata),
    .is_pad_i    (s_axis_tuser),
    .push_o      (q_push),
    .push_data_o (q_in),
    .status_o    (front_st)
  );

  vsf_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_in),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  vsf_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .w_i         (w),
    .plane_i     (plane),
    .mode_i      (mode_q),
    .coef_i      (coef_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  `VSF_ASSERT_IMP(a_full_not_empty, clk_i, rst_ni, !q_ready, q_valid)
  `VSF_ASSERT_IMP(a_idle_pad_dropped, clk_i, rst_ni,
                  in_accept && s_axis_tuser && front_st.idle, !q_push)
  `VSF_ASSERT_IMP(a_drain_zero, clk_i, rst_ni, q_push && front_st.draining, q_in.voxel == 8'd0)
  `VSF_ASSERT_NXT(a_push_fills, clk_i, rst_ni, q_push && !q_pop, q_valid)

endmodule
